/* rtl/a32dec_pkg.sv */
// a32dec_pkg: instruction class codes and shared types for the A32 class decoder.
// No dependencies.
package a32dec_pkg;

   typedef logic [7:0] class_type;

   localparam class_type K_UNDEF = 8'd0;
   localparam class_type K_AND_RS = 8'd1;
   localparam class_type K_LSL_R = 8'd14;
   localparam class_type K_BIC_RS = 8'd18;
   localparam class_type K_MVN_RS = 8'd19;
   localparam class_type K_AND_R = 8'd20;
   localparam class_type K_MOV_R = 8'd33;
   localparam class_type K_LSL_I = 8'd34;
   localparam class_type K_LSR_I = 8'd35;
   localparam class_type K_ASR_I = 8'd36;
   localparam class_type K_RRX = 8'd37;
   localparam class_type K_ROR_I = 8'd38;
   localparam class_type K_BIC_R = 8'd39;
   localparam class_type K_MVN_R = 8'd40;
   localparam class_type K_STR_R = 8'd41;
   localparam class_type K_STRT_R = 8'd42;
   localparam class_type K_LDR_R = 8'd43;
   localparam class_type K_LDRT_R = 8'd44;
   localparam class_type K_STRB_R = 8'd45;
   localparam class_type K_STRBT_R = 8'd46;
   localparam class_type K_LDRB_R = 8'd47;
   localparam class_type K_LDRBT_R = 8'd48;
   localparam class_type K_STR_I = 8'd49;
   localparam class_type K_STRT_I = 8'd50;
   localparam class_type K_LDR_L = 8'd51;
   localparam class_type K_LDR_I = 8'd52;
   localparam class_type K_LDRT_I = 8'd53;
   localparam class_type K_STRB_I = 8'd54;
   localparam class_type K_STRBT_I = 8'd55;
   localparam class_type K_LDRB_L = 8'd56;
   localparam class_type K_LDRB_I = 8'd57;
   localparam class_type K_LDRBT_I = 8'd58;
   localparam class_type K_SADD16 = 8'd59;
   localparam class_type K_PKH = 8'd77;
   localparam class_type K_SXTAB16 = 8'd78;
   localparam class_type K_SXTB16 = 8'd79;
   localparam class_type K_SEL = 8'd80;
   localparam class_type K_SSAT = 8'd81;
   localparam class_type K_SSAT16 = 8'd82;
   localparam class_type K_SXTAB = 8'd83;
   localparam class_type K_SXTB = 8'd84;
   localparam class_type K_REV = 8'd85;
   localparam class_type K_SXTAH = 8'd86;
   localparam class_type K_SXTH = 8'd87;
   localparam class_type K_REV16 = 8'd88;
   localparam class_type K_UXTAB16 = 8'd89;
   localparam class_type K_UXTB16 = 8'd90;
   localparam class_type K_USAT = 8'd91;
   localparam class_type K_USAT16 = 8'd92;
   localparam class_type K_UXTAB = 8'd93;
   localparam class_type K_UXTB = 8'd94;
   localparam class_type K_RBIT = 8'd95;
   localparam class_type K_UXTAH = 8'd96;
   localparam class_type K_UXTH = 8'd97;
   localparam class_type K_REVSH = 8'd98;
   localparam class_type K_SMLAD = 8'd99;
   localparam class_type K_SMUAD = 8'd100;
   localparam class_type K_SMLSD = 8'd101;
   localparam class_type K_SMUSD = 8'd102;
   localparam class_type K_SDIV = 8'd103;
   localparam class_type K_UDIV = 8'd104;
   localparam class_type K_SMLALD = 8'd105;
   localparam class_type K_SMLSLD = 8'd106;
   localparam class_type K_SMMLA = 8'd107;
   localparam class_type K_SMMUL = 8'd108;
   localparam class_type K_SMMLS = 8'd109;
   localparam class_type K_USAD8 = 8'd110;
   localparam class_type K_USADA8 = 8'd111;
   localparam class_type K_SBFX = 8'd112;
   localparam class_type K_BFC = 8'd113;
   localparam class_type K_BFI = 8'd114;
   localparam class_type K_UBFX = 8'd115;
   localparam class_type K_STMDA = 8'd116;
   localparam class_type K_LDMDA = 8'd117;
   localparam class_type K_STM = 8'd118;
   localparam class_type K_LDM = 8'd119;
   localparam class_type K_POP = 8'd120;
   localparam class_type K_STMDB = 8'd121;
   localparam class_type K_PUSH = 8'd122;
   localparam class_type K_LDMDB = 8'd123;
   localparam class_type K_STMIB = 8'd124;
   localparam class_type K_LDMIB = 8'd125;
   localparam class_type K_STM_USR = 8'd126;
   localparam class_type K_LDM_USR = 8'd127;
   localparam class_type K_LDM_EXRET = 8'd128;
   localparam class_type K_B = 8'd129;
   localparam class_type K_BLX = 8'd130;
   localparam class_type K_BL = 8'd131;
   localparam class_type K_SVC = 8'd132;
   localparam class_type K_STC = 8'd133;
   localparam class_type K_LDC_I = 8'd134;
   localparam class_type K_LDC_L = 8'd135;
   localparam class_type K_MCRR = 8'd136;
   localparam class_type K_MRRC = 8'd137;
   localparam class_type K_CDP = 8'd138;
   localparam class_type K_MCR = 8'd139;
   localparam class_type K_MRC = 8'd140;
   localparam class_type K_CPS = 8'd141;
   localparam class_type K_SETEND = 8'd142;
   localparam class_type K_UNPRED = 8'd143;
   localparam class_type K_NOP = 8'd144;
   localparam class_type K_PLI_I = 8'd145;
   localparam class_type K_PLD_I = 8'd146;
   localparam class_type K_PLD_L = 8'd147;
   localparam class_type K_CLREX = 8'd148;
   localparam class_type K_DSB = 8'd149;
   localparam class_type K_DMB = 8'd150;
   localparam class_type K_ISB = 8'd151;
   localparam class_type K_PLI_R = 8'd152;
   localparam class_type K_PLD_R = 8'd153;
   localparam class_type K_SRS = 8'd154;
   localparam class_type K_RFE = 8'd155;
   localparam class_type K_STC2 = 8'd156;
   localparam class_type K_LDC2_L = 8'd157;
   localparam class_type K_LDC2_I = 8'd158;
   localparam class_type K_MCRR2 = 8'd159;
   localparam class_type K_MRRC2 = 8'd160;
   localparam class_type K_CDP2 = 8'd161;
   localparam class_type K_MCR2 = 8'd162;
   localparam class_type K_MRC2 = 8'd163;

   localparam logic [3:0] COND_ALWAYS_NV = 4'hf;
   localparam logic [3:0] REG_PC = 4'hf;
   localparam logic [3:0] REG_SP = 4'hd;

   typedef struct packed {
      logic [31:0] instruction_word;
   } req_type;

   typedef struct packed {
      class_type instruction_class;
      logic      is_unpredictable;
   } rsp_type;

endpackage

/* rtl/a32dec_if.sv */
// a32dec_if: valid/ready channel carrying one payload struct.
// Depends on nothing; payload type is a type parameter.
interface a32dec_if #(parameter type PAYLOAD_TYPE = logic [31:0]) ();
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/a32dec_cond.sv */
// a32dec_cond: class decode of words with a condition other than 0xF.
// Depends on a32dec_pkg.
module a32dec_cond import a32dec_pkg::*; (
   input  logic [31:0] w,
   output class_type   cls
);

   function automatic class_type alu_group(input logic [4:0] op, input class_type base);
      class_type r;
      r = K_UNDEF;
      if (op[4] == 1'b0) r = base + class_type'(op[4:1]);
      else if (op == 5'h11) r = base + 8'd8;
      else if (op == 5'h13) r = base + 8'd9;
      else if (op == 5'h15) r = base + 8'd10;
      else if (op == 5'h17) r = base + 8'd11;
      else if (op[4:1] == 4'hc) r = base + 8'd12;
      return r;
   endfunction

   function automatic class_type dp_shreg(input logic [31:0] x);
      class_type r;
      if (x[24:21] == 4'hd) r = K_LSL_R + class_type'(x[6:5]);
      else if (x[24:21] == 4'he) r = K_BIC_RS;
      else if (x[24:21] == 4'hf) r = K_MVN_RS;
      else r = alu_group(x[24:20], K_AND_RS);
      return r;
   endfunction

   function automatic class_type dp_reg(input logic [31:0] x);
      class_type r;
      logic      z;
      z = (x[11:7] == 5'd0);
      if (x[24:21] == 4'hd) begin
         case (x[6:5])
            2'd0: r = z ? K_MOV_R : K_LSL_I;
            2'd1: r = K_LSR_I;
            2'd2: r = K_ASR_I;
            default: r = z ? K_RRX : K_ROR_I;
         endcase
      end else if (x[24:21] == 4'he) r = K_BIC_R;
      else if (x[24:21] == 4'hf) r = K_MVN_R;
      else r = alu_group(x[24:20], K_AND_R);
      return r;
   endfunction

   function automatic class_type dp_misc(input logic [31:0] x);
      class_type r;
      logic      ms;
      ms = (x[24:20] & 5'h19) == 5'h10;
      r = K_UNDEF;
      if (!x[25] && !ms) begin
         if (!x[4]) r = dp_reg(x);
         else if (!x[7]) r = dp_shreg(x);
      end
      return r;
   endfunction

   function automatic class_type ldst(input logic [31:0] x);
      class_type  r;
      logic [2:0] k;
      logic       t;
      logic       lit;
      k = {x[22], 1'b0, x[20]};
      t = ~x[24] & x[21];
      lit = (x[19:16] == REG_PC);
      if (x[25]) begin
         if (x[4]) r = K_UNDEF;
         else begin
            case (k)
               3'd0: r = t ? K_STRT_R : K_STR_R;
               3'd1: r = t ? K_LDRT_R : K_LDR_R;
               3'd4: r = t ? K_STRBT_R : K_STRB_R;
               default: r = t ? K_LDRBT_R : K_LDRB_R;
            endcase
         end
      end else begin
         case (k)
            3'd0: r = t ? K_STRT_I : K_STR_I;
            3'd1: r = t ? K_LDRT_I : (lit ? K_LDR_L : K_LDR_I);
            3'd4: r = t ? K_STRBT_I : K_STRB_I;
            default: r = t ? K_LDRBT_I : (lit ? K_LDRB_L : K_LDRB_I);
         endcase
      end
      return r;
   endfunction

   function automatic class_type par_addsub(input logic [31:0] x);
      class_type  r;
      logic [2:0] idx;
      logic       ok;
      ok = 1'b1;
      idx = x[7:5];
      if (x[7:5] == 3'd7) idx = 3'd5;
      else if (x[7:5] > 3'd4) ok = 1'b0;
      if (x[21:20] == 2'd0 || !ok) r = K_UNDEF;
      else r = K_SADD16 + 8'd6 * class_type'(x[21:20] - 2'd1) + class_type'(idx);
      return r;
   endfunction

   function automatic class_type packing(input logic [31:0] x);
      class_type  r;
      logic [2:0] o1;
      logic [2:0] o2;
      logic       a;
      o1 = x[22:20];
      o2 = x[7:5];
      a = (x[19:16] == REG_PC);
      r = K_UNDEF;
      if (o1 == 3'd0 && !o2[0]) r = K_PKH;
      else if (o1 == 3'd0 && o2 == 3'd3) r = a ? K_SXTB16 : K_SXTAB16;
      else if (o1 == 3'd0 && o2 == 3'd5) r = K_SEL;
      else if (o1[2:1] == 2'd1 && !o2[0]) r = K_SSAT;
      else if (o1 == 3'd2 && o2 == 3'd1) r = K_SSAT16;
      else if (o1 == 3'd2 && o2 == 3'd3) r = a ? K_SXTB : K_SXTAB;
      else if (o1 == 3'd3 && o2 == 3'd1) r = K_REV;
      else if (o1 == 3'd3 && o2 == 3'd3) r = a ? K_SXTH : K_SXTAH;
      else if (o1 == 3'd3 && o2 == 3'd5) r = K_REV16;
      else if (o1 == 3'd4 && o2 == 3'd3) r = a ? K_UXTB16 : K_UXTAB16;
      else if (o1[2:1] == 2'd3 && !o2[0]) r = K_USAT;
      else if (o1 == 3'd6 && o2 == 3'd1) r = K_USAT16;
      else if (o1 == 3'd6 && o2 == 3'd3) r = a ? K_UXTB : K_UXTAB;
      else if (o1 == 3'd7 && o2 == 3'd1) r = K_RBIT;
      else if (o1 == 3'd7 && o2 == 3'd3) r = a ? K_UXTH : K_UXTAH;
      else if (o1 == 3'd7 && o2 == 3'd5) r = K_REVSH;
      return r;
   endfunction

   function automatic class_type smul_div(input logic [31:0] x);
      class_type  r;
      logic [2:0] o1;
      logic [2:0] o2;
      logic [1:0] h;
      logic       a;
      o1 = x[22:20];
      o2 = x[7:5];
      h = o2[2:1];
      a = (x[15:12] == REG_PC);
      r = K_UNDEF;
      if (o1 == 3'd0 && h == 2'd0) r = a ? K_SMUAD : K_SMLAD;
      else if (o1 == 3'd0 && h == 2'd1) r = a ? K_SMUSD : K_SMLSD;
      else if (o1 == 3'd1 && o2 == 3'd0) r = K_SDIV;
      else if (o1 == 3'd3 && o2 == 3'd0) r = K_UDIV;
      else if (o1 == 3'd4 && h == 2'd0) r = K_SMLALD;
      else if (o1 == 3'd4 && h == 2'd1) r = K_SMLSLD;
      else if (o1 == 3'd5 && h == 2'd0) r = a ? K_SMMUL : K_SMMLA;
      else if (o1 == 3'd5 && h == 2'd3) r = K_SMMLS;
      return r;
   endfunction

   function automatic class_type media(input logic [31:0] x);
      class_type  r;
      logic [4:0] o1;
      o1 = x[24:20];
      r = K_UNDEF;
      if (o1[4:3] == 2'b00) r = par_addsub(x);
      else if (o1[4:3] == 2'b01) r = packing(x);
      else if (o1[4:3] == 2'b10) r = smul_div(x);
      else if (o1 == 5'h18 && x[7:5] == 3'd0)
         r = (x[15:12] == REG_PC) ? K_USAD8 : K_USADA8;
      else if (o1[4:1] == 4'hd && x[6:5] == 2'd2) r = K_SBFX;
      else if (o1[4:1] == 4'he && x[6:5] == 2'd0)
         r = (x[3:0] == REG_PC) ? K_BFC : K_BFI;
      else if (o1[4:1] == 4'hf && x[6:5] == 2'd2) r = K_UBFX;
      return r;
   endfunction

   function automatic class_type block_branch(input logic [31:0] x);
      class_type  r;
      logic [5:0] op;
      logic       sp;
      op = x[25:20];
      sp = (x[19:16] == REG_SP);
      if (op == 6'h00 || op == 6'h02) r = K_STMDA;
      else if (op == 6'h01 || op == 6'h03) r = K_LDMDA;
      else if (op == 6'h08 || op == 6'h0a) r = K_STM;
      else if (op == 6'h09) r = K_LDM;
      else if (op == 6'h0b) r = sp ? K_POP : K_LDM;
      else if (op == 6'h10) r = K_STMDB;
      else if (op == 6'h12) r = sp ? K_PUSH : K_STMDB;
      else if (op == 6'h11 || op == 6'h13) r = K_LDMDB;
      else if (op == 6'h18 || op == 6'h1a) r = K_STMIB;
      else if (op == 6'h19 || op == 6'h1b) r = K_LDMIB;
      else if ((op & 6'h25) == 6'h04) r = K_STM_USR;
      else if ((op & 6'h25) == 6'h05) r = x[15] ? K_LDM_EXRET : K_LDM_USR;
      else if (op[5:4] == 2'b10) r = K_B;
      else r = K_BL;
      return r;
   endfunction

   function automatic class_type copro_svc(input logic [31:0] x);
      class_type  r;
      logic [5:0] o1;
      o1 = x[25:20];
      r = K_UNDEF;
      if (o1 <= 6'd1) r = K_UNDEF;
      else if (o1[5:4] == 2'b11) r = K_SVC;
      else if (x[11:8] == 4'd10 || x[11:8] == 4'd11) r = K_UNDEF;
      else if ((o1 & 6'h21) == 6'h00 && (o1 & 6'h3b) != 6'h00) r = K_STC;
      else if ((o1 & 6'h21) == 6'h01 && (o1 & 6'h3b) != 6'h01)
         r = (x[19:16] != REG_PC) ? K_LDC_I : K_LDC_L;
      else if (o1 == 6'd4) r = K_MCRR;
      else if (o1 == 6'd5) r = K_MRRC;
      else if (o1[5:4] == 2'b10 && !x[4]) r = K_CDP;
      else if ((o1 & 6'h31) == 6'h20 && x[4]) r = K_MCR;
      else if ((o1 & 6'h31) == 6'h21 && x[4]) r = K_MRC;
      return r;
   endfunction

   always_comb begin
      case (w[27:25])
         3'd0, 3'd1: cls = dp_misc(w);
         3'd2: cls = ldst(w);
         3'd3: cls = w[4] ? media(w) : ldst(w);
         3'd4, 3'd5: cls = block_branch(w);
         default: cls = copro_svc(w);
      endcase
   end

endmodule

/* rtl/a32dec_uncond.sv */
// a32dec_uncond: class decode of words with condition 0xF.
// Depends on a32dec_pkg.
module a32dec_uncond import a32dec_pkg::*; (
   input  logic [31:0] w,
   output class_type   cls
);

   logic [7:0] op1;
   logic [3:0] op2;
   logic [3:0] rn;
   class_type  hint_cls;

   assign op1 = w[27:20];
   assign op2 = w[7:4];
   assign rn  = w[19:16];

   always_comb begin
      case (op1)
         8'h10: begin
            if (!op2[1] && !rn[0]) hint_cls = K_CPS;
            else if (op2 == 4'd0 && rn[0]) hint_cls = K_SETEND;
            else hint_cls = K_UNDEF;
         end
         8'h12: hint_cls = (op2 == 4'd7) ? K_UNPRED : K_UNDEF;
         8'h41, 8'h49: hint_cls = K_NOP;
         8'h45, 8'h4d: hint_cls = K_PLI_I;
         8'h51, 8'h59: hint_cls = (rn == REG_PC) ? K_UNPRED : K_PLD_I;
         8'h55, 8'h5d: hint_cls = (rn == REG_PC) ? K_PLD_L : K_PLD_I;
         8'h53: hint_cls = K_UNPRED;
         8'h57: begin
            case (op2)
               4'd1: hint_cls = K_CLREX;
               4'd4: hint_cls = K_DSB;
               4'd5: hint_cls = K_DMB;
               4'd6: hint_cls = K_ISB;
               default: hint_cls = K_UNPRED;
            endcase
         end
         8'h5b, 8'h5f: hint_cls = K_UNPRED;
         8'h61, 8'h69: hint_cls = op2[0] ? K_UNDEF : K_NOP;
         8'h65, 8'h6d: hint_cls = op2[0] ? K_UNDEF : K_PLI_R;
         8'h71, 8'h75, 8'h79, 8'h7d: hint_cls = op2[0] ? K_UNDEF : K_PLD_R;
         default: begin
            if ((op1 & 8'h77) == 8'h43) hint_cls = K_UNPRED;
            else if ((op1 & 8'h63) == 8'h63 && !op2[0]) hint_cls = K_UNPRED;
            else hint_cls = K_UNDEF;
         end
      endcase
   end

   always_comb begin
      cls = K_UNDEF;
      if (!op1[7]) cls = hint_cls;
      else if (op1[7:5] == 3'd4 && op1[2] && !op1[0]) cls = K_SRS;
      else if (op1[7:5] == 3'd4 && !op1[2] && op1[0]) cls = K_RFE;
      else if (op1[7:5] == 3'd5) cls = K_BLX;
      else if (op1[7:5] == 3'd6 && !op1[0] && op1 != 8'hc0 && op1 != 8'hc4) cls = K_STC2;
      else if (op1[7:5] == 3'd6 && op1[0] && op1 != 8'hc1 && op1 != 8'hc5)
         cls = (rn == REG_PC) ? K_LDC2_L : K_LDC2_I;
      else if (op1 == 8'hc4) cls = K_MCRR2;
      else if (op1 == 8'hc5) cls = K_MRRC2;
      else if (op1[7:4] == 4'he) begin
         if (!w[4]) cls = K_CDP2;
         else cls = op1[0] ? K_MRC2 : K_MCR2;
      end
   end

endmodule

/* rtl/a32_instruction_class_decoder_unit.sv */
// a32_instruction_class_decoder_unit: top level of the A32 instruction class decoder.
// Depends on a32dec_pkg, a32dec_if, a32dec_cond and a32dec_uncond.
//
// Classifies one 32-bit A32 instruction word per transaction into a dense class
// code (0 = undefined) plus an unpredictable flag. A word is taken into the input
// register, decoded combinationally by the conditional and unconditional trees and
// written into the result register once that stage advances (two register stages).
// Throughput is one transaction per cycle: the input stage advances whenever the
// result register is empty or being drained, so a stall on the result side holds
// both stages and backs up into req_ready.
module a32_instruction_class_decoder_unit import a32dec_pkg::*; (
   input logic clock,
   input logic reset,
   a32dec_if.sink   req,
   a32dec_if.source rsp
);

   logic        in_valid_ff, in_valid_in;
   logic [31:0] in_word_ff, in_word_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_data_ff, out_data_in;
   class_type   cond_cls, uncond_cls, cls;
   logic        out_adv, in_adv;

   // Result register advances when empty or drained this cycle.
   assign out_adv = !out_valid_ff || rsp.ready;
   // Input register advances when empty or moving into the result stage.
   assign in_adv  = !in_valid_ff || out_adv;
   assign req.ready = in_adv;

   a32dec_cond u_cond (.w(in_word_ff), .cls(cond_cls));
   a32dec_uncond u_uncond (.w(in_word_ff), .cls(uncond_cls));

   // Condition 0xF selects the unconditional tree.
   assign cls = (in_word_ff[31:28] == COND_ALWAYS_NV) ? uncond_cls : cond_cls;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (in_adv) begin
         in_valid_in = req.valid;
         in_word_in  = req.payload.instruction_word;
      end
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_adv) begin
         out_valid_in = in_valid_ff;
         out_data_in.instruction_class = cls;
         out_data_in.is_unpredictable  = (cls == K_UNPRED);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_word_ff  <= in_word_in;
      out_data_ff <= out_data_in;
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_data_ff;

`ifndef SYNTHESIS
   a_flag_matches: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.payload.is_unpredictable ==
                     (rsp.payload.instruction_class == K_UNPRED)))
      else $error("unpredictable flag disagrees with class");
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_adv) |=> in_valid_ff)
      else $error("held input transaction lost");
   a_fill_out: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_adv) |=> out_valid_ff)
      else $error("decoded transaction not placed in result register");
`endif

endmodule
